[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
// ante implies cons at the same clock edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/b64d_pkg.sv]
// shared types and constants of the base64 stream decoder
package b64d_pkg;

  localparam int QUEUE_DEPTH = 4;

  // one unit of work for the output side: 1 to 3 bytes of a group or an error
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    logic        err;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/base64_stream_decoder_core.sv]
// base64 stream decoder top level
// Input channel: one character per transaction on char_in with last_in marking
// the end of a message (in_valid / in_ready). Output channel: one decoded byte
// per transaction on byte_out with error_out and last_out (out_valid / out_ready).
// The input side takes one character per cycle while the job queue has room;
// every fourth character, or an error, pushes one job of 1 to 3 bytes.
// The output side sends one byte per cycle while out_ready is high; a full group
// drains before the next completes, and the stream keeps one character per cycle.
// out_valid for the first byte of a group, or an error, rises once the job has
// been written into the queue and then loaded into the output job register,
// when the queue and the output side are idle.
// An error gives a single transaction with byte_out 0, error_out 1, last_out 1;
// after it, characters are dropped up to and including the one with last_in.
// When the receiver stalls, the current byte holds, the queue of QueueDepth jobs
// fills and in_ready drops until the output side frees a slot.
// Reset clears the group position, padding mark, discard flag and the queue;
// no clearing pass is needed and in_ready is high the cycle after reset.
module base64_stream_decoder_core import b64d_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       error_out,
  output logic       last_out
);

  q_status_t q_status;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_in  (char_in),
    .last_in  (last_in),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_out  (byte_out),
    .error_out (error_out),
    .last_out  (last_out)
  );

endmodule

[rtl/b64d_front.sv]
// input side: character classification, group collection and job generation
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_in,
  input  q_status_t  q_status,
  output logic       push,
  output job_t       push_job
);

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  // returns {valid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (c == PLUS_CHAR) begin
      r = {1'b1, 6'd62};
    end else if (c == SLASH_CHAR) begin
      r = {1'b1, 6'd63};
    end else if (c == PAD_CHAR) begin
      r = {1'b1, 6'd0};
    end
    return r;
  endfunction

  logic [17:0] accum, accum_next;
  logic [1:0]  pos, pos_next;
  logic        pad_seen, pad_seen_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic [6:0]  dec;
  logic        is_pad;
  logic [1:0]  pads;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign dec      = sextet_of(char_in);
  assign is_pad   = (char_in == PAD_CHAR);
  assign pads     = {1'b0, pad_seen} + {1'b0, is_pad};

  always_comb begin
    accum_next      = accum;
    pos_next        = pos;
    pad_seen_next   = pad_seen;
    discarding_next = discarding;
    push            = 1'b0;
    push_job        = '{word: 24'h0, count: 2'd1, err: 1'b1, last: 1'b1};
    if (accept) begin
      if (discarding) begin
        if (last_in) begin
          discarding_next = 1'b0;
          pos_next        = 2'd0;
          pad_seen_next   = 1'b0;
        end
      end else if (!dec[6]) begin
        pos_next        = 2'd0;
        pad_seen_next   = 1'b0;
        discarding_next = !last_in;
        push            = 1'b1;
      end else if (pos != 2'd3) begin
        accum_next = {accum[11:0], dec[5:0]};
        pos_next   = pos + 2'd1;
        if (pos == 2'd2 && is_pad) begin
          pad_seen_next = 1'b1;
        end
        // message ends inside a group
        if (last_in) begin
          pos_next      = 2'd0;
          pad_seen_next = 1'b0;
          push          = 1'b1;
        end
      end else begin
        push          = 1'b1;
        push_job.word = {accum, dec[5:0]};
        push_job.err  = 1'b0;
        push_job.last = last_in;
        push_job.count = last_in ? (2'd3 - pads) : 2'd3;
        pos_next      = 2'd0;
        pad_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 2'd0;
      pad_seen   <= 1'b0;
      discarding <= 1'b0;
    end else begin
      pos        <= pos_next;
      pad_seen   <= pad_seen_next;
      discarding <= discarding_next;
    end
  end

  // older sextets shift out before a group completes, so no reset is needed
  always_ff @(posedge clk) begin
    accum <= accum_next;
  end

endmodule

[rtl/b64d_queue.sv]
// short job queue between the input side and the output side
`include "assert_macros.svh"
module b64d_queue import b64d_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t q_status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;

  assign q_status.full  = (cnt == CntW'(Depth));
  assign q_status.empty = (cnt == '0);
  assign pop_job        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && q_status.full, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && q_status.empty, "pop from empty queue")
  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt > CntW'(Depth), "queue count beyond depth")

endmodule

[rtl/b64d_back.sv]
// output side: turns queued jobs into one byte transaction per cycle while out_ready is high
`include "assert_macros.svh"
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  job_t       pop_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       error_out,
  output logic       last_out
);

  job_t       job;
  logic       job_valid;
  logic [1:0] idx;
  logic       fire;
  logic       done;

  assign fire      = job_valid && out_ready;
  assign done      = fire && (idx == job.count - 2'd1);
  assign pop       = !q_status.empty && (!job_valid || done);
  assign out_valid = job_valid;
  assign error_out = job.err;
  assign last_out  = job.last && (idx == job.count - 2'd1);

  always_comb begin
    case (idx)
      2'd0:    byte_out = job.word[23:16];
      2'd1:    byte_out = job.word[15:8];
      default: byte_out = job.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      job_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      job_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
  end

  `ASSERT_IMPLY(a_count_nz, clk, rst, job_valid, job.count != 2'd0, "job with no bytes")
  `ASSERT_IMPLY(a_err_single, clk, rst, job_valid && job.err, job.last && job.count == 2'd1, "error job not single and last")
  `ASSERT_IMPLY(a_idx_range, clk, rst, job_valid, idx < job.count, "byte index past job count")

endmodule
